>>> design/rtfs_pkg.sv
// Shared constants, codes and controller/datapath types for the frame slave.
`timescale 1ns / 1ps
package rtfs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int TIMER_BITS  = 16;
  localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_BITS    = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  localparam int FRAME_LEN   = 7;
  localparam int POS_BITS    = 3;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_ID = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT = 1'd1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] TYPE_READ  = 8'd0;
  localparam logic [7:0] TYPE_WRITE = 8'd1;

  localparam logic [7:0] ID_ENTRY   = 8'd1;
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] ENTRY0_RST = 8'hFF;

  localparam logic [2:0] NODE_ID_RST = 3'd1;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input item transfers this cycle
    logic write;     // a matching write frame completes this cycle
    logic read_hi;   // table read address is address + 1
    logic cap_lo;    // capture the first reply entry
    logic cap_hi;    // capture the second reply entry
    logic send_step; // a reply byte transfers this cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_done; // the current byte is the last one of a frame
    logic id_match;
    logic is_read;
    logic is_write;
    logic send_last;  // the reply byte on offer is the final one
  } status_t;

endpackage

>>> design/rtfs_if.sv
// Valid/ready channel interfaces for received items and reply bytes.
`timescale 1ns / 1ps
interface rtfs_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface rtfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

>>> design/rtfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rtfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rtfs_datapath.sv
// Frame capture, tick timer, register table and reply byte selection.
`timescale 1ns / 1ps
module rtfs_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rtfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rtfs_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  operation,
  input  logic [7:0]                            rx_byte,
  input  rtfs_pkg::cmd_t                        cmd,
  output rtfs_pkg::status_t                     status,
  output logic [7:0]                            tx_byte,
  output logic                                  last_byte
);
  import rtfs_pkg::*;

  logic [2:0]            node_id;
  logic [15:0]           timeout_ticks;
  logic [POS_BITS-1:0]   byte_position;
  logic [TIMER_BITS-1:0] elapsed_ticks;
  logic                  timer_running;
  logic [7:0]            id_byte;
  logic [7:0]            addr_byte;
  logic [7:0]            type_byte;
  logic [7:0]            data1_byte;
  logic [7:0]            entry_lo;
  logic [7:0]            entry_hi;
  logic [POS_BITS-1:0]   send_idx;
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic [TIMER_BITS-1:0] elapsed_next;
  logic                  timed_out;
  logic [8:0]            lo_addr;
  logic [8:0]            hi_addr;
  logic                  lo_in_range;
  logic                  hi_in_range;
  logic [ADDR_BITS-1:0]  lo_idx;
  logic [ADDR_BITS-1:0]  hi_idx;
  logic                  wr_en;
  logic [7:0]            ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id       <= NODE_ID_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID: node_id       <= cfg_data[2:0];
        CFG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The counter saturates, so a timeout above its maximum never fires.
  assign elapsed_next = (elapsed_ticks == {TIMER_BITS{1'b1}}) ? elapsed_ticks
                                                               : elapsed_ticks + 1'b1;
  assign timed_out = CMP_BITS'(elapsed_next) >= CMP_BITS'(timeout_ticks);

  assign status.frame_done = (operation == OP_BYTE) &&
                             (byte_position == POS_BITS'(FRAME_LEN - 1));
  assign status.id_match   = id_byte == {5'd0, node_id};
  assign status.is_read    = type_byte == TYPE_READ;
  assign status.is_write   = type_byte == TYPE_WRITE;
  assign status.send_last  = send_idx == POS_BITS'(FRAME_LEN - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      elapsed_ticks <= '0;
      timer_running <= 1'b0;
    end else if (cmd.take) begin
      if (operation == OP_TICK) begin
        if (timer_running) begin
          if (timed_out) begin
            byte_position <= '0;
            elapsed_ticks <= '0;
            timer_running <= 1'b0;
          end else begin
            elapsed_ticks <= elapsed_next;
          end
        end
      end else if (status.frame_done) begin
        byte_position <= '0;
        elapsed_ticks <= '0;
        timer_running <= 1'b0;
      end else begin
        if (byte_position == '0) begin
          timer_running <= 1'b1;
          elapsed_ticks <= '0;
        end
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  // Only the id, address, type and data1 positions matter at frame end.
  always_ff @(posedge clk) begin
    if (cmd.take && operation == OP_BYTE) begin
      case (byte_position)
        3'd2:    id_byte    <= rx_byte;
        3'd3:    addr_byte  <= rx_byte;
        3'd4:    type_byte  <= rx_byte;
        3'd5:    data1_byte <= rx_byte;
        default: ;
      endcase
    end
  end

  assign lo_addr     = {1'b0, addr_byte};
  assign hi_addr     = lo_addr + 9'd1;
  assign lo_in_range = lo_addr < 9'(TABLE_DEPTH);
  assign hi_in_range = hi_addr < 9'(TABLE_DEPTH);
  assign lo_idx      = lo_addr[ADDR_BITS-1:0];
  assign hi_idx      = hi_addr[ADDR_BITS-1:0];

  assign wr_en = cmd.write && (addr_byte != ID_ENTRY) && lo_in_range;

  rtfs_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (lo_idx),
    .wdata (data1_byte),
    .raddr (cmd.read_hi ? hi_idx : lo_idx),
    .rdata (ram_q)
  );

  // Entries never written read as their reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[lo_idx] <= 1'b1;
    end
  end

  function automatic logic [7:0] resolve(input logic [8:0] a, input logic in_range,
                                         input logic [ADDR_BITS-1:0] idx,
                                         input logic vld, input logic [7:0] q,
                                         input logic [2:0] nid);
    logic [7:0] r;
    if (a == {1'b0, ID_ENTRY}) begin
      r = {5'd0, nid};
    end else if (!in_range) begin
      r = 8'd0;
    end else if (vld) begin
      r = q;
    end else begin
      r = (idx == '0) ? ENTRY0_RST : 8'd0;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      entry_lo <= resolve(lo_addr, lo_in_range, lo_idx, entry_valid[lo_idx], ram_q, node_id);
    end
    if (cmd.cap_hi) begin
      entry_hi <= resolve(hi_addr, hi_in_range, hi_idx, entry_valid[hi_idx], ram_q, node_id);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_idx <= '0;
    end else if (cmd.send_step) begin
      send_idx <= status.send_last ? '0 : send_idx + 1'b1;
    end
  end

  always_comb begin
    unique case (send_idx)
      3'd0, 3'd1: tx_byte = SYNC_BYTE;
      3'd3:       tx_byte = addr_byte;
      3'd5:       tx_byte = entry_lo;
      3'd6:       tx_byte = entry_hi;
      default:    tx_byte = 8'd0;
    endcase
  end

  assign last_byte = status.send_last;

endmodule

>>> design/rtfs_ctrl.sv
// Controller state machine: item intake, table read sequence and reply send.
`timescale 1ns / 1ps
module rtfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rtfs_pkg::status_t status,
  output rtfs_pkg::cmd_t    cmd
);
  import rtfs_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ_LO = 3'd1;
  localparam logic [2:0] S_READ_HI = 3'd2;
  localparam logic [2:0] S_LOAD    = 3'd3;
  localparam logic [2:0] S_SEND    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;
  logic       frame_ok;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_SEND;
  assign take      = in_valid && in_ready;
  assign frame_ok  = take && status.frame_done && status.id_match;

  assign cmd.take      = take;
  assign cmd.write     = frame_ok && status.is_write;
  assign cmd.read_hi   = state == S_READ_HI;
  assign cmd.cap_lo    = state == S_READ_HI;
  assign cmd.cap_hi    = state == S_LOAD;
  assign cmd.send_step = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (frame_ok && status.is_read) begin
          state_next = S_READ_LO;
        end
      end
      S_READ_LO: state_next = S_READ_HI;
      S_READ_HI: state_next = S_LOAD;
      S_LOAD:    state_next = S_SEND;
      S_SEND: begin
        if (out_ready && status.send_last) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/register_table_frame_slave_core.sv
// Top level: 7-byte frame slave with a byte register table and read replies.
// Bytes and ticks are taken only while idle. A read frame's last byte starts
// a read of two table entries through one RAM port, then the 7 reply bytes
// go out one per cycle while reply.ready is high; input waits meanwhile.
// Synchronous reset drops any partial frame, stops the timer, sets node id 1
// and timeout 1000; the table reads 0xFF at entry 0 and zero from entry 2 up.
`timescale 1ns / 1ps
module register_table_frame_slave_core (
  input  logic                                clk,
  input  logic                                rst,
  rtfs_in_if.sink                             frame,
  rtfs_out_if.source                          reply,
  input  logic                                cfg_we,
  input  logic [rtfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rtfs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rtfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  rtfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (reply.valid),
    .out_ready (reply.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtfs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operation (frame.operation),
    .rx_byte   (frame.rx_byte),
    .cmd       (cmd),
    .status    (status),
    .tx_byte   (reply.tx_byte),
    .last_byte (reply.last_byte)
  );

endmodule
